// ===== hw/rtl/adts_ts_pkg.sv =====
// Package for the ADTS AAC frame timestamper: widths, lookup tables,
// sequencer state type and the divider status struct.
// No dependencies.
`default_nettype none

package adts_ts_pkg;

   localparam int DIVIDEND_W = 59;               // 32-bit count times 27-bit constant
   localparam int DIVISOR_W  = 17;               // sample rate in Hz
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int COUNT_W    = 32;
   localparam int OFFSET_W   = 47;
   localparam int PTS_W      = 48;
   localparam int TIME_W     = 40;
   localparam int SIZE_W     = 16;
   localparam int FLEN_W     = 13;

   localparam logic [3:0]          RATE_COUNT    = 4'd13;
   localparam logic [26:0]         SAMPLES_X_90K = 27'd92160000;
   localparam logic [6:0]          TICKS_PER_MS  = 7'd90;
   localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;
   localparam logic [7:0]          DURATION_RST  = 8'd21;
   localparam logic [7:0]          SYNC_BYTE     = 8'hFF;
   localparam logic [3:0]          SYNC_NIBBLE   = 4'hF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Sampling-frequency index to rate in Hz; 0 for reserved codes.
   function automatic logic [DIVISOR_W-1:0] rate_lookup(input logic [3:0] idx);
      logic [DIVISOR_W-1:0] rate;
      unique case (idx)
         4'd0:    rate = 17'd96000;
         4'd1:    rate = 17'd88200;
         4'd2:    rate = 17'd64000;
         4'd3:    rate = 17'd48000;
         4'd4:    rate = 17'd44100;
         4'd5:    rate = 17'd32000;
         4'd6:    rate = 17'd24000;
         4'd7:    rate = 17'd22050;
         4'd8:    rate = 17'd16000;
         4'd9:    rate = 17'd12000;
         4'd10:   rate = 17'd11025;
         4'd11:   rate = 17'd8000;
         4'd12:   rate = 17'd7350;
         default: rate = '0;
      endcase
      return rate;
   endfunction

   // Frame duration in ms, 1024000 / rate rounded down.
   function automatic logic [7:0] duration_lookup(input logic [3:0] idx);
      logic [7:0] dur;
      unique case (idx)
         4'd0:    dur = 8'd10;
         4'd1:    dur = 8'd11;
         4'd2:    dur = 8'd16;
         4'd3:    dur = 8'd21;
         4'd4:    dur = 8'd23;
         4'd5:    dur = 8'd32;
         4'd6:    dur = 8'd42;
         4'd7:    dur = 8'd46;
         4'd8:    dur = 8'd64;
         4'd9:    dur = 8'd85;
         4'd10:   dur = 8'd92;
         4'd11:   dur = 8'd128;
         4'd12:   dur = 8'd139;
         default: dur = DURATION_RST;
      endcase
      return dur;
   endfunction

   // Channel configuration to channel count.
   function automatic logic [3:0] chan_lookup(input logic [2:0] cfg);
      logic [3:0] cnt;
      unique case (cfg)
         3'd7:    cnt = 4'd8;
         default: cnt = {1'b0, cfg};
      endcase
      return cnt;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/adts_ts_if.sv =====
// Valid/ready channel interfaces for the ADTS AAC frame timestamper.
// Depends on nothing; widths follow the header, size, time and PTS fields.
`default_nettype none

interface adts_ts_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  hdr_byte0;
   logic [7:0]  hdr_byte1;
   logic [7:0]  hdr_byte2;
   logic [7:0]  hdr_byte3;
   logic [7:0]  hdr_byte4;
   logic [7:0]  hdr_byte5;
   logic [15:0] frame_size;
   logic [39:0] time_ms;
   logic        restart;

   modport source (
      output valid, hdr_byte0, hdr_byte1, hdr_byte2, hdr_byte3, hdr_byte4, hdr_byte5,
             frame_size, time_ms, restart,
      input  ready
   );
   modport sink (
      input  valid, hdr_byte0, hdr_byte1, hdr_byte2, hdr_byte3, hdr_byte4, hdr_byte5,
             frame_size, time_ms, restart,
      output ready
   );
endinterface

interface adts_ts_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] pts_90khz;
   logic        pts_valid;
   logic [16:0] sample_rate_hz;
   logic [7:0]  frame_duration_ms;
   logic [3:0]  channel_count;
   logic        channel_valid;
   logic        header_valid;

   modport source (
      output valid, pts_90khz, pts_valid, sample_rate_hz, frame_duration_ms,
             channel_count, channel_valid, header_valid,
      input  ready
   );
   modport sink (
      input  valid, pts_90khz, pts_valid, sample_rate_hz, frame_duration_ms,
             channel_count, channel_valid, header_valid,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/adts_aac_frame_timestamper.sv =====
// ADTS AAC frame timestamper. Takes one frame header transfer, looks up the
// sample rate and channel count, checks the header, and returns one result
// transfer carrying a 90 kHz PTS of count*92160000/rate + offset. A frame with
// a valid rate index goes through the divider, which makes one quotient bit
// per cycle over the 59-bit product; a frame with a reserved rate index
// skips the divider. One frame is handled at a time; the next request is
// taken once the previous result has been moved into the output register.
// Depends on adts_ts_pkg, adts_ts_if and adts_ts_divider.
`default_nettype none

module adts_aac_frame_timestamper
   import adts_ts_pkg::*;
#(
   parameter int HEADER_LEN = 7
)(
   input  wire logic     clock,
   input  wire logic     reset,
   adts_ts_req_if.sink   req_chan,
   adts_ts_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;

   logic                  accept;
   logic                  div_start;
   logic                  load_out;
   logic [3:0]            idx;
   logic                  idx_ok;
   logic [COUNT_W-1:0]    eff_count;
   logic                  first_frame;
   logic                  sync;
   logic                  size_ok;
   logic [FLEN_W-1:0]     flen;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVIDEND_W-1:0] quotient;
   div_status_type        div_sts;

   logic [COUNT_W-1:0]    frame_count_ff, frame_count_in;
   logic [OFFSET_W-1:0]   time_offset_ff, time_offset_in;
   logic [7:0]            duration_ff, duration_in;

   // side fields held while the divide runs
   logic                  pend_pvalid_ff;
   logic [DIVISOR_W-1:0]  pend_rate_ff;
   logic [3:0]            pend_ccount_ff;
   logic                  pend_cvalid_ff;
   logic                  pend_hvalid_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [PTS_W-1:0]      out_pts_ff;
   logic                  out_pvalid_ff;
   logic [DIVISOR_W-1:0]  out_rate_ff;
   logic [7:0]            out_duration_ff;
   logic [3:0]            out_ccount_ff;
   logic                  out_cvalid_ff;
   logic                  out_hvalid_ff;

   adts_ts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (rate_lookup(idx)),
      .quotient (quotient),
      .status   (div_sts)
   );

   // request decode
   always_comb begin
      idx         = req_chan.hdr_byte2[5:2];
      idx_ok      = idx < RATE_COUNT;
      eff_count   = req_chan.restart ? '0 : frame_count_ff;
      first_frame = eff_count == '0;
      dividend    = DIVIDEND_W'(eff_count) * DIVIDEND_W'(SAMPLES_X_90K);
      sync        = (req_chan.hdr_byte0 == SYNC_BYTE) &&
                    (req_chan.hdr_byte1[7:4] == SYNC_NIBBLE);
      size_ok     = req_chan.frame_size >= SIZE_W'(HEADER_LEN);
      flen        = {req_chan.hdr_byte3[1:0], req_chan.hdr_byte4, req_chan.hdr_byte5[7:5]};
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               accept    = 1'b1;
               div_start = idx_ok;
               state_in  = idx_ok ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // frame state updates on request transfer
   always_comb begin
      frame_count_in = frame_count_ff;
      time_offset_in = time_offset_ff;
      duration_in    = duration_ff;
      if (accept) begin
         frame_count_in = eff_count;
         if (idx_ok) begin
            if (eff_count != COUNT_MAX) begin
               frame_count_in = eff_count + 1'b1;
            end
            if (first_frame) begin
               time_offset_in = OFFSET_W'(req_chan.time_ms) * OFFSET_W'(TICKS_PER_MS);
               duration_in    = duration_lookup(idx);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         time_offset_ff <= '0;
         duration_ff    <= DURATION_RST;
      end else begin
         frame_count_ff <= frame_count_in;
         time_offset_ff <= time_offset_in;
         duration_ff    <= duration_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_pvalid_ff <= idx_ok;
         pend_rate_ff   <= rate_lookup(idx);
         pend_cvalid_ff <= sync && size_ok;
         pend_ccount_ff <= (sync && size_ok) ?
                           chan_lookup({req_chan.hdr_byte2[0], req_chan.hdr_byte3[7:6]}) :
                           4'd0;
         pend_hvalid_ff <= sync && size_ok && ({3'b000, flen} == req_chan.frame_size);
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_pts_ff      <= pend_pvalid_ff ?
                            quotient[PTS_W-1:0] + PTS_W'(time_offset_ff) : '0;
         out_pvalid_ff   <= pend_pvalid_ff;
         out_rate_ff     <= pend_rate_ff;
         out_duration_ff <= duration_ff;
         out_ccount_ff   <= pend_ccount_ff;
         out_cvalid_ff   <= pend_cvalid_ff;
         out_hvalid_ff   <= pend_hvalid_ff;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.pts_90khz         = out_pts_ff;
   assign rsp_chan.pts_valid         = out_pvalid_ff;
   assign rsp_chan.sample_rate_hz    = out_rate_ff;
   assign rsp_chan.frame_duration_ms = out_duration_ff;
   assign rsp_chan.channel_count     = out_ccount_ff;
   assign rsp_chan.channel_valid     = out_cvalid_ff;
   assign rsp_chan.header_valid      = out_hvalid_ff;

   // divider only reports completion while the sequencer waits for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIVIDE)
      else $error("divider done outside divide state");

   // frame count only moves forward unless a restart is taken
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.restart |=> frame_count_ff >= $past(frame_count_ff))
      else $error("frame count went backward without restart");

   // a reserved rate index yields zero PTS and zero rate
   a_invalid_rate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.pts_valid |->
         rsp_chan.pts_90khz == '0 && rsp_chan.sample_rate_hz == '0)
      else $error("invalid rate result carries nonzero timing");

   // no channel count without a valid channel indication
   a_channel_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.channel_valid |-> rsp_chan.channel_count == '0)
      else $error("channel count set while channel not valid");

   // a divider start is followed by the divide state with the divider busy
   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIVIDE && div_sts.busy)
      else $error("divider start did not enter divide state");

endmodule

`default_nettype wire

// ===== hw/rtl/adts_ts_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on adts_ts_pkg for widths and the status struct.
`default_nettype none

module adts_ts_divider
   import adts_ts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output      logic [DIVIDEND_W-1:0] quotient,
   output      div_status_type        status
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial    = {rem_ff, dq_ff[DIVIDEND_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      fits     = trial >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIVIDEND_W - 1);
         rem_in   = '0;
         dq_in    = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // shift next dividend bit in, subtract when it fits
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dq_in    = {dq_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      dsr_ff   <= dsr_in;
   end

   assign quotient = dq_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

`default_nettype wire
